// ----- src/assert_macros.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pixel_blend_write_unit: assertion failed");

// Antecedent on one edge, consequent on the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_blend_write_unit: assertion failed");

`endif

// ----- src/pbwu_pkg.sv -----
package pbwu_pkg;

  localparam int FB_WIDTH_DEF  = 256;
  localparam int FB_HEIGHT_DEF = 256;

  // Request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Blend modes
  localparam logic [3:0] MODE_STORE = 4'd0;
  localparam logic [3:0] MODE_XOR   = 4'd1;
  localparam logic [3:0] MODE_AND   = 4'd2;
  localparam logic [3:0] MODE_OR    = 4'd3;
  localparam logic [3:0] MODE_ADDW  = 4'd4;
  localparam logic [3:0] MODE_ADDS  = 4'd5;
  localparam logic [3:0] MODE_SUBW  = 4'd6;
  localparam logic [3:0] MODE_SUBS  = 4'd7;
  localparam logic [3:0] MODE_ROTL  = 4'd8;
  localparam logic [3:0] MODE_ROTR  = 4'd9;
  localparam logic [3:0] MODE_SHL   = 4'd10;
  localparam logic [3:0] MODE_SHR   = 4'd11;
  localparam logic [3:0] MODE_FIRST_BAD = 4'd12;

  localparam logic [4:0] PIX_MAX = 5'd31;

  typedef struct packed {
    logic               kind;
    logic signed [11:0] x_coord;
    logic signed [11:0] y_coord;
    logic        [4:0]  color_value;
    logic        [3:0]  blend_mode;
  } pix_req_t;

  typedef struct packed {
    logic [4:0] read_data;
    logic       in_range;
    logic       pixel_written;
    logic       bad_mode;
  } pix_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write zero at clear pointer, advance it
    logic accept;  // latch request, compute address
    logic commit;  // write blended pixel, load result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ----- src/pixel_blend_write_unit.sv -----
// Raster-operation unit over a framebuffer of 5-bit pixels, FB_WIDTH x FB_HEIGHT,
// row-major. The pixel channel (pixel_valid / pixel_stall / pixel) carries one
// request: a read, or a write that blends color_value into the stored pixel
// under blend_mode. The result channel (result_valid / result_stall / result)
// returns exactly one result per request, in order.
// Sequence: the address is formed and registered in the accepting cycle, the
// registered memory read follows in the read state, and the exec state blends,
// writes back and loads the result register once that register is free.
// Requests do not overlap: pixel_stall stays high from accept until commit, as
// the frame memory is updated by read-modify-write.
// Reset: the controller sweeps the store, one pixel a cycle, writing zero,
// and pixel_stall stays high until it is done.
// Receiver stall: the result register holds its request's result; the unit
// still takes and processes the next request, and waits before commit until
// the register frees, so no result is lost or overwritten.
`include "assert_macros.svh"

module pixel_blend_write_unit #(
  parameter int FB_WIDTH  = pbwu_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = pbwu_pkg::FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  pbwu_pkg::pix_req_t pixel,
  output logic               result_valid,
  input  logic               result_stall,
  output pbwu_pkg::pix_rsp_t result
);

  // Command and status between sequencer and datapath
  pbwu_pkg::dp_cmd_t    cmd;
  pbwu_pkg::dp_status_t status;

  // Sequencer: clear sweep, request accept, memory read, commit
  pbwu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  // Datapath: address, frame memory, blend, result register
  pbwu_dp #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

  // Hold off further requests while one is in flight
  `ASSERT_NEXT(a_busy_after_accept, pixel_valid && !pixel_stall, pixel_stall)
  // Never overwrite a result the receiver has not taken
  `ASSERT_CLK(a_no_overwrite, cmd.commit |-> !(result_valid && result_stall))
  // A new result only comes from a commit
  `ASSERT_CLK(a_rise_from_commit, $rose(result_valid) |-> $past(cmd.commit))
  // A stored pixel implies an in-range write with a good mode
  `ASSERT_CLK(a_write_flags,
    result_valid && result.pixel_written |-> result.in_range && !result.bad_mode)

endmodule

// ----- src/pbwu_ctrl.sv -----
module pbwu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  output logic                result_valid,
  input  logic                result_stall,
  output pbwu_pkg::dp_cmd_t   cmd,
  input  pbwu_pkg::dp_status_t status
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign pixel_stall = (state != ST_IDLE);
  assign slot_free   = !result_valid || !result_stall;

  always_comb begin
    cmd.clear  = (state == ST_CLEAR);
    cmd.accept = (state == ST_IDLE) && pixel_valid;
    cmd.commit = (state == ST_EXEC) && slot_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (pixel_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/pbwu_dp.sv -----
module pbwu_dp #(
  parameter int FB_WIDTH  = pbwu_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = pbwu_pkg::FB_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbwu_pkg::pix_req_t   pixel,
  output pbwu_pkg::pix_rsp_t   result,
  input  pbwu_pkg::dp_cmd_t    cmd,
  output pbwu_pkg::dp_status_t status
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = 23;

  logic [4:0]    mem [DEPTH];

  logic [AW-1:0] clr_ptr;
  logic [AW-1:0] addr;
  logic          kind;
  logic [4:0]    color;
  logic [3:0]    mode;
  logic          in_range;
  logic [4:0]    rdata;

  logic [11:0]   xu;
  logic [11:0]   yu;
  logic [LW-1:0] lin;
  logic          in_range_now;
  logic          bad;
  logic          wr_ok;
  logic [4:0]    blended;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [4:0]    mem_wdata;
  pbwu_pkg::pix_rsp_t rsp_now;

  function automatic logic [4:0] blend(input logic [3:0] m,
                                       input logic [4:0] s,
                                       input logic [4:0] c);
    logic [5:0]  sum;
    logic [15:0] dbl;
    logic [15:0] rl;
    logic [15:0] rr;
    logic [4:0]  r;
    sum = {1'b0, s} + {1'b0, c};
    dbl = {3'b000, s, 3'b000, s};
    rl  = dbl << c[2:0];
    rr  = dbl >> c[2:0];
    case (m)
      pbwu_pkg::MODE_STORE: r = c;
      pbwu_pkg::MODE_XOR:   r = s ^ c;
      pbwu_pkg::MODE_AND:   r = s & c;
      pbwu_pkg::MODE_OR:    r = s | c;
      pbwu_pkg::MODE_ADDW:  r = sum[4:0];
      pbwu_pkg::MODE_ADDS:  r = sum[5] ? pbwu_pkg::PIX_MAX : sum[4:0];
      pbwu_pkg::MODE_SUBW:  r = s - c;
      pbwu_pkg::MODE_SUBS:  r = (s > c) ? (s - c) : 5'd0;
      pbwu_pkg::MODE_ROTL:  r = rl[12:8];
      pbwu_pkg::MODE_ROTR:  r = rr[4:0];
      pbwu_pkg::MODE_SHL:   r = (c < 5'd5) ? (s << c) : 5'd0;
      pbwu_pkg::MODE_SHR:   r = (c < 5'd5) ? (s >> c) : 5'd0;
      default:              r = 5'd0;
    endcase
    return r;
  endfunction

  // Address and range from the incoming request
  assign xu  = pixel.x_coord;
  assign yu  = pixel.y_coord;
  assign lin = LW'(yu[10:0]) * LW'(FB_WIDTH) + LW'(xu[10:0]);
  assign in_range_now = !xu[11] && !yu[11] &&
                        (xu < 12'(FB_WIDTH)) && (yu < 12'(FB_HEIGHT));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr     <= lin[AW-1:0];
      kind     <= pixel.kind;
      color    <= pixel.color_value;
      mode     <= pixel.blend_mode;
      in_range <= in_range_now;
    end
  end

  // Clear pointer sweeps the store once after reset
  assign status.clear_last = (clr_ptr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_ptr <= clr_ptr + AW'(1);
    end
  end

  assign bad     = (kind == pbwu_pkg::KIND_WRITE) && (mode >= pbwu_pkg::MODE_FIRST_BAD);
  assign wr_ok   = (kind == pbwu_pkg::KIND_WRITE) && !bad && in_range;
  assign blended = blend(mode, rdata, color);

  assign mem_we    = cmd.clear || (cmd.commit && wr_ok);
  assign mem_waddr = cmd.clear ? clr_ptr : addr;
  assign mem_wdata = cmd.clear ? 5'd0 : blended;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  always_comb begin
    rsp_now.read_data     = ((kind == pbwu_pkg::KIND_READ) && in_range) ? rdata : 5'd0;
    rsp_now.in_range      = in_range;
    rsp_now.pixel_written = wr_ok;
    rsp_now.bad_mode      = bad;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= rsp_now;
    end
  end

endmodule
